[design/dps_pkg.sv]
// Shared types and constants of the dynamic priority scheduler.
`timescale 1ns / 1ps

package dps_pkg;

  localparam int FW       = 16;  // priority / slice field width
  localparam int ID_OUT_W = 4;   // process id width on the result channel
  localparam int ST_W     = 2;   // proc_state width
  localparam int CNT_W    = 7;   // count width in the status struct

  localparam logic [ST_W-1:0] PS_READY    = 2'd0;
  localparam logic [ST_W-1:0] PS_RUNNING  = 2'd1;
  localparam logic [ST_W-1:0] PS_FINISHED = 2'd2;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [FW-1:0] PRIO_MIN = 16'h8000;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b00_0000_0001,
    S_POP     = 10'b00_0000_0010,
    S_RUN_RD  = 10'b00_0000_0100,
    S_RUN_CHK = 10'b00_0000_1000,
    S_ROW_RD  = 10'b00_0001_0000,
    S_ROW_OUT = 10'b00_0010_0000,
    S_UPD     = 10'b00_0100_0000,
    S_INS_RD  = 10'b00_1000_0000,
    S_INS_CMP = 10'b01_0000_0000,
    S_INS_PUT = 10'b10_0000_0000
  } seq_state_t;

  typedef struct packed {
    logic          prio_we;
    logic          need_we;
    logic          used_we;
    logic [FW-1:0] prio;
    logic [FW-1:0] need;
    logic [FW-1:0] used;
  } ptab_wr_t;

  typedef struct packed {
    logic [FW-1:0] prio;
    logic [FW-1:0] need;
    logic [FW-1:0] used;
  } ptab_rd_t;

  typedef struct packed {
    logic             idle;
    logic [CNT_W-1:0] ready_cnt;
    logic [CNT_W-1:0] fin_cnt;
    logic [CNT_W-1:0] load_cnt;
  } dps_stat_t;

endpackage

[design/dps_if.sv]
// Request and status-row channel interfaces of the scheduler.
`timescale 1ns / 1ps

interface dps_in_if;
  import dps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic                 op;
  logic signed [FW-1:0] priority_req;
  logic        [FW-1:0] needed_time;

  modport source (output valid, output op, output priority_req, output needed_time,
                  input ready);
  modport sink   (input valid, input op, input priority_req, input needed_time,
                  output ready);
endinterface

interface dps_out_if;
  import dps_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [ST_W-1:0]      proc_state;
  logic [ID_OUT_W-1:0]  process_id;
  logic signed [FW-1:0] cur_priority;
  logic [FW-1:0]        need_slices;
  logic [FW-1:0]        used_slices;
  logic                 all_done;
  logic                 last;

  modport source (output valid, output proc_state, output process_id, output cur_priority,
                  output need_slices, output used_slices, output all_done, output last,
                  input ready);
  modport sink   (input valid, input proc_state, input process_id, input cur_priority,
                  input need_slices, input used_slices, input all_done, input last,
                  output ready);
endinterface

[design/dps_ptab.sv]
// Process table: priority, needed and used slices per process id.
`timescale 1ns / 1ps

module dps_ptab #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic [AW-1:0]     wr_addr,
  input  dps_pkg::ptab_wr_t wr,
  input  logic [AW-1:0]     rd_addr,
  output dps_pkg::ptab_rd_t rd
);
  import dps_pkg::*;

  logic [FW-1:0] prio_mem [DEPTH];
  logic [FW-1:0] need_mem [DEPTH];
  logic [FW-1:0] used_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr.prio_we) begin
      prio_mem[wr_addr] <= wr.prio;
    end
    if (wr.need_we) begin
      need_mem[wr_addr] <= wr.need;
    end
    if (wr.used_we) begin
      used_mem[wr_addr] <= wr.used;
    end
  end

  always_ff @(posedge clk) begin
    rd.prio <= prio_mem[rd_addr];
    rd.need <= need_mem[rd_addr];
    rd.used <= used_mem[rd_addr];
  end

endmodule

[design/dps_ctrl.sv]
// Scheduler sequencer: ready/finished lists, shared compare unit, row output register.
`timescale 1ns / 1ps

module dps_ctrl #(
  parameter int MAX_PROCS = 16,
  parameter int IDW       = 4,
  parameter int CW        = 5
) (
  input  logic               clk,
  input  logic               rst_n,
  dps_in_if.sink             in_ch,
  dps_out_if.source          out_ch,
  output logic [IDW-1:0]     wr_addr,
  output dps_pkg::ptab_wr_t  wr,
  output logic [IDW-1:0]     rd_addr,
  input  dps_pkg::ptab_rd_t  rd,
  output dps_pkg::dps_stat_t stat
);
  import dps_pkg::*;

  seq_state_t state_r, state_nxt;

  logic [IDW-1:0] rdy_r [MAX_PROCS];
  logic [IDW-1:0] rdy_nxt [MAX_PROCS];
  logic [IDW-1:0] fin_r [MAX_PROCS];
  logic [IDW-1:0] fin_nxt [MAX_PROCS];

  logic [CW-1:0]  rcnt_r, rcnt_nxt;
  logic [CW-1:0]  fcnt_r, fcnt_nxt;
  logic [CW-1:0]  lcnt_r, lcnt_nxt;
  logic [CW-1:0]  scan_r, scan_nxt;      // row index and insert position
  logic [ST_W-1:0] kind_r, kind_nxt;     // state code of the row being walked
  logic           have_run_r, have_run_nxt;
  logic           done_r, done_nxt;
  logic           all_done_r, all_done_nxt;
  logic [IDW-1:0] run_id_r, run_id_nxt;
  logic [FW-1:0]  run_prio_r, run_prio_nxt;
  logic [FW-1:0]  run_used1_r, run_used1_nxt;
  logic [IDW-1:0] nid_r, nid_nxt;
  logic [FW-1:0]  np_r, np_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [ST_W-1:0]     o_state_r, o_state_nxt;
  logic [ID_OUT_W-1:0] o_id_r, o_id_nxt;
  logic [FW-1:0]       o_prio_r, o_prio_nxt;
  logic [FW-1:0]       o_need_r, o_need_nxt;
  logic [FW-1:0]       o_used_r, o_used_nxt;
  logic                o_all_done_r, o_all_done_nxt;
  logic                o_last_r, o_last_nxt;

  logic [IDW-1:0] scan_idx;
  logic [IDW-1:0] row_id;
  logic [CW-1:0]  scan_inc;
  logic           row_last;
  logic           out_free;
  logic           in_acc;
  logic [FW-1:0]  used_inc;
  logic [FW-1:0]  aged_prio;
  logic           np_higher;

  assign scan_idx = scan_r[IDW-1:0];
  assign scan_inc = scan_r + CW'(1);
  assign out_free = !out_valid_r || out_ch.ready;
  assign in_acc   = in_ch.valid && in_ch.ready;

  // shared arithmetic
  assign used_inc  = rd.used + FW'(1);
  assign aged_prio = (run_prio_r == PRIO_MIN) ? run_prio_r : run_prio_r - FW'(1);
  assign np_higher = $signed(np_r) > $signed(rd.prio);

  always_comb begin
    case (kind_r)
      PS_RUNNING: row_id = run_id_r;
      PS_READY:   row_id = rdy_r[scan_idx];
      default:    row_id = fin_r[scan_idx];
    endcase
  end

  always_comb begin
    case (kind_r)
      PS_RUNNING:  row_last = (rcnt_r == '0) && (fcnt_r == '0);
      PS_READY:    row_last = (scan_inc == rcnt_r) && (fcnt_r == '0);
      PS_FINISHED: row_last = (scan_inc == fcnt_r);
      default:     row_last = 1'b1;
    endcase
  end

  always_comb begin
    case (state_r)
      S_RUN_RD: rd_addr = run_id_r;
      S_INS_RD: rd_addr = rdy_r[scan_idx];
      default:  rd_addr = row_id;
    endcase
  end

  always_comb begin
    state_nxt      = state_r;
    rdy_nxt        = rdy_r;
    fin_nxt        = fin_r;
    rcnt_nxt       = rcnt_r;
    fcnt_nxt       = fcnt_r;
    lcnt_nxt       = lcnt_r;
    scan_nxt       = scan_r;
    kind_nxt       = kind_r;
    have_run_nxt   = have_run_r;
    done_nxt       = done_r;
    all_done_nxt   = all_done_r;
    run_id_nxt     = run_id_r;
    run_prio_nxt   = run_prio_r;
    run_used1_nxt  = run_used1_r;
    nid_nxt        = nid_r;
    np_nxt         = np_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    o_state_nxt    = o_state_r;
    o_id_nxt       = o_id_r;
    o_prio_nxt     = o_prio_r;
    o_need_nxt     = o_need_r;
    o_used_nxt     = o_used_r;
    o_all_done_nxt = o_all_done_r;
    o_last_nxt     = o_last_r;
    wr_addr        = run_id_r;
    wr             = '0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_ch.op == OP_LOAD) begin
            if (lcnt_r < CW'(MAX_PROCS)) begin
              wr_addr    = lcnt_r[IDW-1:0];
              wr.prio_we = 1'b1;
              wr.need_we = 1'b1;
              wr.used_we = 1'b1;
              wr.prio    = in_ch.priority_req;
              wr.need    = in_ch.needed_time;
              wr.used    = '0;
              nid_nxt    = lcnt_r[IDW-1:0];
              np_nxt     = in_ch.priority_req;
              lcnt_nxt   = lcnt_r + CW'(1);
              scan_nxt   = '0;
              state_nxt  = S_INS_RD;
            end
          end else if (lcnt_r != '0) begin
            state_nxt = S_POP;
          end
        end
      end

      S_POP: begin
        scan_nxt = '0;
        if (rcnt_r != '0) begin
          run_id_nxt   = rdy_r[0];
          for (int j = 0; j < MAX_PROCS - 1; j++) begin
            rdy_nxt[j] = rdy_r[j+1];
          end
          rcnt_nxt     = rcnt_r - CW'(1);
          have_run_nxt = 1'b1;
          state_nxt    = S_RUN_RD;
        end else begin
          // only finished processes left: no running row
          have_run_nxt = 1'b0;
          all_done_nxt = 1'b1;
          kind_nxt     = PS_FINISHED;
          state_nxt    = S_ROW_RD;
        end
      end

      S_RUN_RD: begin
        state_nxt = S_RUN_CHK;
      end

      S_RUN_CHK: begin
        run_prio_nxt  = rd.prio;
        run_used1_nxt = used_inc;
        done_nxt      = (used_inc == rd.need);
        all_done_nxt  = (rcnt_r == '0) && (used_inc == rd.need);
        kind_nxt      = PS_RUNNING;
        state_nxt     = S_ROW_RD;
      end

      S_ROW_RD: begin
        state_nxt = S_ROW_OUT;
      end

      S_ROW_OUT: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          o_state_nxt    = kind_r;
          o_id_nxt       = ID_OUT_W'(row_id);
          o_prio_nxt     = rd.prio;
          o_need_nxt     = rd.need;
          o_used_nxt     = rd.used;
          o_all_done_nxt = all_done_r;
          o_last_nxt     = row_last;
          if (row_last) begin
            state_nxt = have_run_r ? S_UPD : S_IDLE;
          end else begin
            state_nxt = S_ROW_RD;
            case (kind_r)
              PS_RUNNING: begin
                scan_nxt = '0;
                kind_nxt = (rcnt_r != '0) ? PS_READY : PS_FINISHED;
              end
              PS_READY: begin
                if (scan_inc == rcnt_r) begin
                  scan_nxt = '0;
                  kind_nxt = PS_FINISHED;
                end else begin
                  scan_nxt = scan_inc;
                end
              end
              default: begin
                scan_nxt = scan_inc;
              end
            endcase
          end
        end
      end

      S_UPD: begin
        wr_addr    = run_id_r;
        wr.used_we = 1'b1;
        wr.used    = run_used1_r;
        wr.prio    = aged_prio;
        if (done_r) begin
          if (fcnt_r < CW'(MAX_PROCS)) begin
            fin_nxt[0] = run_id_r;
            for (int j = 1; j < MAX_PROCS; j++) begin
              fin_nxt[j] = fin_r[j-1];
            end
            fcnt_nxt = fcnt_r + CW'(1);
          end
          state_nxt = S_IDLE;
        end else begin
          wr.prio_we = 1'b1;
          nid_nxt    = run_id_r;
          np_nxt     = aged_prio;
          scan_nxt   = '0;
          state_nxt  = S_INS_RD;
        end
      end

      S_INS_RD: begin
        // end of list reached: append
        state_nxt = (scan_r == rcnt_r) ? S_INS_PUT : S_INS_CMP;
      end

      S_INS_CMP: begin
        if (np_higher) begin
          state_nxt = S_INS_PUT;
        end else begin
          scan_nxt  = scan_inc;
          state_nxt = S_INS_RD;
        end
      end

      S_INS_PUT: begin
        if (rcnt_r < CW'(MAX_PROCS)) begin
          if (scan_r == '0) begin
            rdy_nxt[0] = nid_r;
          end
          for (int j = 1; j < MAX_PROCS; j++) begin
            if (CW'(j) > scan_r) begin
              rdy_nxt[j] = rdy_r[j-1];
            end else if (CW'(j) == scan_r) begin
              rdy_nxt[j] = nid_r;
            end
          end
          rcnt_nxt = rcnt_r + CW'(1);
        end
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rcnt_r      <= '0;
      fcnt_r      <= '0;
      lcnt_r      <= '0;
      out_valid_r <= 1'b0;
      have_run_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rcnt_r      <= rcnt_nxt;
      fcnt_r      <= fcnt_nxt;
      lcnt_r      <= lcnt_nxt;
      out_valid_r <= out_valid_nxt;
      have_run_r  <= have_run_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rdy_r        <= rdy_nxt;
    fin_r        <= fin_nxt;
    scan_r       <= scan_nxt;
    kind_r       <= kind_nxt;
    done_r       <= done_nxt;
    all_done_r   <= all_done_nxt;
    run_id_r     <= run_id_nxt;
    run_prio_r   <= run_prio_nxt;
    run_used1_r  <= run_used1_nxt;
    nid_r        <= nid_nxt;
    np_r         <= np_nxt;
    o_state_r    <= o_state_nxt;
    o_id_r       <= o_id_nxt;
    o_prio_r     <= o_prio_nxt;
    o_need_r     <= o_need_nxt;
    o_used_r     <= o_used_nxt;
    o_all_done_r <= o_all_done_nxt;
    o_last_r     <= o_last_nxt;
  end

  assign in_ch.ready         = (state_r == S_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.proc_state   = o_state_r;
  assign out_ch.process_id   = o_id_r;
  assign out_ch.cur_priority = o_prio_r;
  assign out_ch.need_slices  = o_need_r;
  assign out_ch.used_slices  = o_used_r;
  assign out_ch.all_done     = o_all_done_r;
  assign out_ch.last         = o_last_r;

  assign stat.idle      = (state_r == S_IDLE);
  assign stat.ready_cnt = CNT_W'(rcnt_r);
  assign stat.fin_cnt   = CNT_W'(fcnt_r);
  assign stat.load_cnt  = CNT_W'(lcnt_r);

endmodule

[design/dynamic_priority_scheduler.sv]
// Dynamic priority scheduler with aging: top level.
// One request at a time. A load request writes the process table and walks the ready
// list with one compare per entry to find its slot behind every entry of equal or higher
// priority. A tick pops the head of the ready list, then emits one status row per loaded
// process (running, ready in list order, finished newest first), then ages and re-inserts
// the running process by the same walk, or moves it to the finished list when it finishes.
// The process table has a single read port, which serves the row readout and the sorted
// insert in turn. Output stalls hold the row walk; the last row is held in an output
// register so the next request can be taken while it waits.
`timescale 1ns / 1ps

module dynamic_priority_scheduler #(
  parameter int MAX_PROCS = 16
) (
  input logic       clk,
  input logic       rst_n,
  dps_in_if.sink    in_ch,
  dps_out_if.source out_ch
);
  import dps_pkg::*;

  localparam int IDW = $clog2(MAX_PROCS);
  localparam int CW  = $clog2(MAX_PROCS + 1);

  logic [IDW-1:0] wr_addr;
  logic [IDW-1:0] rd_addr;
  ptab_wr_t       wr;
  ptab_rd_t       rd;
  dps_stat_t      stat;

  dps_ptab #(
    .DEPTH (MAX_PROCS),
    .AW    (IDW)
  ) u_ptab (
    .clk     (clk),
    .wr_addr (wr_addr),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd)
  );

  dps_ctrl #(
    .MAX_PROCS (MAX_PROCS),
    .IDW       (IDW),
    .CW        (CW)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .wr_addr (wr_addr),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd      (rd),
    .stat    (stat)
  );

  // every process is in at most one list; the running one is in neither
  a_list_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (CNT_W + 1)'(stat.ready_cnt) + (CNT_W + 1)'(stat.fin_cnt) <= (CNT_W + 1)'(stat.load_cnt))
    else $error("ready plus finished exceeds loaded processes");

  a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.load_cnt <= CNT_W'(MAX_PROCS))
    else $error("loaded count beyond capacity");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && stat.idle && in_ch.op == OP_LOAD && stat.load_cnt < CNT_W'(MAX_PROCS))
    |=> stat.load_cnt == $past(stat.load_cnt) + CNT_W'(1))
    else $error("accepted load not counted");

endmodule

[sim/tb_dynamic_priority_scheduler.sv]
// Self-checking testbench of the dynamic priority scheduler: loads and ticks against a predictor.
`timescale 1ns / 1ps

module tb_dynamic_priority_scheduler;
  import dps_pkg::*;

  localparam int MAX_PROCS    = 16;
  localparam int DIR_N        = 16;
  localparam int RAND_N       = 300;
  localparam int IDLE_PCT     = 36;
  localparam int STALL_LIMIT  = 3000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [ST_W-1:0]     st;
    logic [ID_OUT_W-1:0] id;
    logic [FW-1:0]       prio;
    logic [FW-1:0]       need;
    logic [FW-1:0]       used;
    logic                done;
    logic                last;
  } row_t;

  // how a directed request is checked: by the predictor, or against typed-in rows
  typedef enum logic [1:0] {BY_MODEL, NO_ROWS, ONE_ROW} exp_kind_t;

  typedef struct packed {
    logic      op;
    logic [FW-1:0] prio;
    logic [FW-1:0] need;
    exp_kind_t kind;
    row_t      row;
  } stim_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  bit   calm = 1'b0;

  dps_in_if  in_ch();
  dps_out_if out_ch();

  dynamic_priority_scheduler #(.MAX_PROCS(MAX_PROCS)) u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always #4 clk = ~clk;

  // Scheduler state as the block should hold it
  logic signed [FW-1:0] prio_tab [MAX_PROCS];
  logic [FW-1:0]        need_tab [MAX_PROCS];
  logic [FW-1:0]        used_tab [MAX_PROCS];
  int                   ready_ids[$];
  int                   done_ids[$];
  int                   n_loaded = 0;

  row_t step_rows[$];
  row_t status_rows[$];

  int n_err = 0;
  int n_rows = 0;
  int n_loads = 0;
  int n_ticks = 0;
  int n_dropped = 0;
  int quiet = 0;

  stim_t plan [DIR_N] = '{
    '{OP_TICK, 16'h0000, 16'd0,     NO_ROWS,  '0},  // nothing loaded yet
    '{OP_LOAD, 16'h7FFF, 16'd1,     NO_ROWS,  '0},
    '{OP_TICK, 16'h0000, 16'd0,     ONE_ROW,
      '{PS_RUNNING, 4'd0, 16'h7FFF, 16'd1, 16'd0, 1'b1, 1'b1}},
    '{OP_TICK, 16'h0000, 16'd0,     ONE_ROW,  // only a finished process left
      '{PS_FINISHED, 4'd0, 16'h7FFF, 16'd1, 16'd1, 1'b1, 1'b1}},
    '{OP_LOAD, 16'h8000, 16'd3,     NO_ROWS,  '0},  // starts on the floor
    '{OP_LOAD, 16'h8001, 16'd0,     NO_ROWS,  '0},  // zero need: never finishes here
    '{OP_TICK, 16'h0000, 16'd0,     BY_MODEL, '0},
    '{OP_TICK, 16'h0000, 16'd0,     BY_MODEL, '0},
    '{OP_TICK, 16'h0000, 16'd0,     BY_MODEL, '0},
    '{OP_LOAD, 16'hFFFF, 16'hFFFF,  NO_ROWS,  '0},
    '{OP_LOAD, 16'h0000, 16'd2,     NO_ROWS,  '0},
    '{OP_LOAD, 16'h0000, 16'd1,     NO_ROWS,  '0},  // ties go behind
    '{OP_TICK, 16'h0000, 16'd0,     BY_MODEL, '0},
    '{OP_TICK, 16'h0000, 16'd0,     BY_MODEL, '0},
    '{OP_TICK, 16'h0000, 16'd0,     BY_MODEL, '0},
    '{OP_TICK, 16'h0000, 16'd0,     BY_MODEL, '0}
  };

  function automatic void ready_insert(input int id);
    int pos;
    int i;
    pos = ready_ids.size();
    i = 0;
    while (i < ready_ids.size()) begin
      if (prio_tab[id] > prio_tab[ready_ids[i]]) begin
        pos = i;
        i = ready_ids.size();
      end else begin
        i++;
      end
    end
    ready_ids.insert(pos, id);
  endfunction

  function automatic row_t status_row(input logic [ST_W-1:0] st, input int id,
                                      input logic done, input logic last);
    row_t r;
    r.st   = st;
    r.id   = id[ID_OUT_W-1:0];
    r.prio = prio_tab[id];
    r.need = need_tab[id];
    r.used = used_tab[id];
    r.done = done;
    r.last = last;
    return r;
  endfunction

  // Rows a request should produce go to step_rows; scheduler state advances.
  function automatic void sched_step(input logic op, input logic [FW-1:0] prio,
                                     input logic [FW-1:0] need);
    int  run_id;
    bit  have_run;
    bit  fin;
    bit  empty_after;
    int  n;
    int  k;
    step_rows.delete();
    if (op == OP_LOAD) begin
      if (n_loaded < MAX_PROCS) begin
        prio_tab[n_loaded] = prio;
        need_tab[n_loaded] = need;
        used_tab[n_loaded] = '0;
        ready_insert(n_loaded);
        n_loaded++;
      end
    end else begin
      have_run = ready_ids.size() > 0;
      run_id = 0;
      fin = 1'b0;
      if (have_run) begin
        run_id = ready_ids.pop_front();
        fin = (used_tab[run_id] + 16'd1) == need_tab[run_id];
      end
      empty_after = (ready_ids.size() == 0) && !(have_run && !fin);
      n = int'(have_run) + ready_ids.size() + done_ids.size();
      k = 0;
      if (have_run) begin
        k++;
        step_rows.push_back(status_row(PS_RUNNING, run_id, empty_after, k == n));
      end
      foreach (ready_ids[i]) begin
        k++;
        step_rows.push_back(status_row(PS_READY, ready_ids[i], empty_after, k == n));
      end
      foreach (done_ids[i]) begin
        k++;
        step_rows.push_back(status_row(PS_FINISHED, done_ids[i], empty_after, k == n));
      end
      if (have_run) begin
        used_tab[run_id] = used_tab[run_id] + 16'd1;
        if (fin) begin
          done_ids.push_front(run_id);
        end else begin
          if (prio_tab[run_id] != $signed(PRIO_MIN)) prio_tab[run_id] = prio_tab[run_id] - 16'sd1;
          ready_insert(run_id);
        end
      end
    end
  endfunction

  task automatic note_mismatch(input string why, input row_t want, input row_t got);
    n_err++;
    if (n_err <= 10) begin
      $display("%0t: %s: want st=%0d id=%0d prio=%0d need=%0d used=%0d done=%0b last=%0b",
               $time, why, want.st, want.id, $signed(want.prio), want.need, want.used,
               want.done, want.last);
      $display("%0t: %s:  got st=%0d id=%0d prio=%0d need=%0d used=%0d done=%0b last=%0b",
               $time, why, got.st, got.id, $signed(got.prio), got.need, got.used,
               got.done, got.last);
    end
  endtask

  task automatic send_req(input logic op, input logic [FW-1:0] prio, input logic [FW-1:0] need,
                          input exp_kind_t kind, input row_t typed);
    @(negedge clk);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.priority_req <= prio;
    in_ch.needed_time  <= need;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    if (op == OP_LOAD) begin
      if (n_loaded >= MAX_PROCS) n_dropped++;
      else n_loads++;
    end else begin
      n_ticks++;
    end
    sched_step(op, prio, need);
    case (kind)
      BY_MODEL: foreach (step_rows[i]) status_rows.push_back(step_rows[i]);
      ONE_ROW:  status_rows.push_back(typed);
      default:  ;
    endcase
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (status_rows.size() != 0) @(negedge clk);
  endtask

  // result side backpressure
  initial begin
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ch.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // status row checker and stall watchdog
  always @(posedge clk) begin
    row_t got;
    row_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got = '{out_ch.proc_state, out_ch.process_id, out_ch.cur_priority, out_ch.need_slices,
              out_ch.used_slices, out_ch.all_done, out_ch.last};
      n_rows++;
      if (status_rows.size() == 0) begin
        note_mismatch("unexpected row", '0, got);
      end else begin
        want = status_rows.pop_front();
        if (got.st !== want.st || got.id !== want.id || got.prio !== want.prio ||
            got.need !== want.need || got.used !== want.used ||
            got.done !== want.done || got.last !== want.last)
          note_mismatch("row mismatch", want, got);
      end
    end
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) quiet = 0;
    else quiet++;
    if (quiet >= STALL_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d rows outstanding",
               quiet, status_rows.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    int k;
    int r;
    bit paused;
    logic [FW-1:0] prio;
    logic [FW-1:0] need;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_LOAD;
    in_ch.priority_req = '0;
    in_ch.needed_time  = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++)
      send_req(plan[i].op, plan[i].prio, plan[i].need, plan[i].kind, plan[i].row);

    // random part: fills the table early, then mostly ticks; loads past full get dropped
    k = 0;
    paused = 1'b0;
    while (k < RAND_N) begin
      calm = (k >= 160 && k < 220);
      if (k == 100 && !paused) begin
        wait_drained();
        paused = 1'b1;
      end
      r = $urandom_range(99);
      prio = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8) - 4);
      case ($urandom_range(7))
        0:       need = 16'($urandom);
        1:       need = 16'($urandom_range(40, 1));
        default: need = 16'($urandom_range(6, 1));
      endcase
      if (n_loaded < MAX_PROCS && r < 15) begin
        send_req(OP_LOAD, prio, need, BY_MODEL, '0);
        k++;
      end else if (n_loaded >= MAX_PROCS && r < 5) begin
        send_req(OP_LOAD, prio, need, BY_MODEL, '0);
      end else begin
        send_req(OP_TICK, prio, need, BY_MODEL, '0);
        k++;
      end
    end
    calm = 1'b0;
    @(negedge clk);
    in_ch.valid <= 1'b0;

    while (status_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Run covered %0d loads (%0d dropped on a full table) and %0d ticks,",
             n_loads, n_dropped, n_ticks);
    $display("with %0d status rows checked and %0d mismatches.", n_rows, n_err);
    if (n_err == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[dynamic_priority_scheduler.f]
design/dps_pkg.sv
design/dps_if.sv
design/dps_ptab.sv
design/dps_ctrl.sv
design/dynamic_priority_scheduler.sv
sim/tb_dynamic_priority_scheduler.sv
